### rtl/cpd_pkg.sv
package cpd_pkg;

    localparam logic [1:0] CMD_WORD    = 2'd0;
    localparam logic [1:0] CMD_CAM_ON  = 2'd1;
    localparam logic [1:0] CMD_CAM_OFF = 2'd2;

    localparam logic [2:0] KIND_PIXEL    = 3'd0;
    localparam logic [2:0] KIND_SYNC     = 3'd1;
    localparam logic [2:0] KIND_COMPLETE = 3'd2;
    localparam logic [2:0] KIND_SHORT    = 3'd3;
    localparam logic [2:0] KIND_OTHER    = 3'd4;
    localparam logic [2:0] KIND_CAM_ON   = 3'd5;
    localparam logic [2:0] KIND_CAM_OFF  = 3'd6;

    localparam logic       CFG_FRAME_BYTES   = 1'b0;
    localparam logic       CFG_TIMEOUT_LIMIT = 1'b1;

    localparam int         ADDR_W  = 20;
    localparam int         COUNT_W = 20;
    localparam int         TMO_W   = 11;

    localparam logic [31:0]        SYNC_MARK = 32'hFF00_FF00;
    localparam logic [31:0]        END_MARK  = 32'hEE11_EE11;
    localparam logic [15:0]        PIXEL_TAG = 16'hA0A0;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_SAT = 20'hF_FFFB;
    localparam logic [COUNT_W-1:0] FRAME_BYTES_RST   = 20'd76800;
    localparam logic [TMO_W-1:0]   TIMEOUT_LIMIT_RST = 11'd1500;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ADDR_W-1:0] write_addr;
        logic [31:0]       write_data;
        logic              rearm;
        logic              last;
    } result_t;

endpackage

### rtl/cpd_ram.sv
module cpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/cpd_out.sv
module cpd_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  cpd_pkg::result_t result,
    output logic             can_load,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [55:0]      m_tdata,  // write_addr, write_data, rearm, zero fill
    output logic [2:0]       m_tuser,  // kind
    output logic             m_tlast
);

    logic             valid_reg;
    logic             valid_next;
    cpd_pkg::result_t res_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, res_reg.rearm, res_reg.write_data, res_reg.write_addr};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

endmodule

### rtl/camera_packet_deframer.sv
// camera packet deframer
// s_* carries link items: tuser is the command (packet word, camera on, camera
// off), tdata the 32-bit link word. m_* carries results: tuser is the kind,
// tdata holds the write address, the pixel word and the rearm flag, tlast marks
// the final result of one input item.
// cfg_wr_en/cfg_index/cfg_data write frame_bytes (0) or timeout_limit (1);
// write only while the block is idle.
// packet words go into a PACKET_WORDS-entry store with a registered read port.
// words that do not finish a packet and camera commands do not hold the input; a
// result, where the item gives one, appears on m_* in the cycle after it is accepted.
// a pixel packet reads the store back one word a cycle while the output register
// can take it; after the last word is accepted the block enters the pixel state,
// which loads PACKET_WORDS-1 writes into the output register and holds the input
// until the last of them is loaded.
// a single output register parts the two sides; when the receiver stalls the
// register holds and s_tready drops until it is taken.
// reset clears the word position, offset, byte count, timeout count, camera
// state and sets the registers to 76800 and 1500.
module camera_packet_deframer #(
    parameter int PACKET_WORDS = 16,
    parameter int OFFSET_BITS  = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // word_in
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // write_addr, write_data, rearm, zero fill
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data
);

    localparam int IDX_W = $clog2(PACKET_WORDS);
    localparam int AW    = cpd_pkg::ADDR_W;
    localparam int CW    = cpd_pkg::COUNT_W;
    localparam int TW    = cpd_pkg::TMO_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_WORDS - 1);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_PIXEL = 1'b1;

    logic              state_reg, state_next;
    logic [IDX_W-1:0]  word_idx_reg, word_idx_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [TW-1:0]     tmo_reg, tmo_next;
    logic              cam_reg, cam_next;
    logic              rearm_reg, rearm_next;
    logic [CW-1:0]     frame_bytes_reg;
    logic [TW-1:0]     tmo_limit_reg;
    logic [31:0]       w0_reg, w1_reg;
    logic [15:0]       prev_low_reg, prev_low_next;

    logic              accept;
    logic              can_load;
    logic              load;
    cpd_pkg::result_t  result;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_raddr;
    logic [31:0]       mem_rdata;
    logic              is_sync, is_end, is_pixel, tmo_hit;
    logic [AW+OFFSET_BITS-1:0] offset_ext;

    assign s_tready   = (state_reg == ST_IDLE) && can_load;
    assign accept     = s_tvalid && s_tready;
    assign mem_we     = accept && (s_tuser == cpd_pkg::CMD_WORD);
    assign offset_ext = {AW'(0), offset_reg};

    assign is_sync  = (w0_reg == cpd_pkg::SYNC_MARK) && (w1_reg == cpd_pkg::SYNC_MARK);
    assign is_end   = (w0_reg == cpd_pkg::END_MARK) && (w1_reg == cpd_pkg::END_MARK);
    assign is_pixel = (w0_reg[31:16] == cpd_pkg::PIXEL_TAG)
                   && (s_tdata[15:0] == cpd_pkg::PIXEL_TAG) && cam_reg;
    assign tmo_hit  = (tmo_reg >= tmo_limit_reg);

    cpd_ram #(
        .WIDTH (32),
        .DEPTH (PACKET_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (word_idx_reg),
        .wdata (s_tdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cpd_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always_comb
    begin
        state_next    = state_reg;
        word_idx_next = word_idx_reg;
        rd_idx_next   = rd_idx_reg;
        offset_next   = offset_reg;
        count_next    = count_reg;
        tmo_next      = tmo_reg;
        cam_next      = cam_reg;
        rearm_next    = rearm_reg;
        prev_low_next = prev_low_reg;
        load          = 1'b0;
        result        = '0;
        result.last   = 1'b1;
        mem_raddr     = IDX_W'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        cpd_pkg::CMD_CAM_ON:
                        begin
                            if (!cam_reg)
                            begin
                                cam_next     = 1'b1;
                                load         = 1'b1;
                                result.kind  = cpd_pkg::KIND_CAM_ON;
                                result.rearm = 1'b1;
                            end
                        end
                        cpd_pkg::CMD_CAM_OFF:
                        begin
                            if (cam_reg)
                            begin
                                cam_next     = 1'b0;
                                offset_next  = '0;
                                count_next   = '0;
                                load         = 1'b1;
                                result.kind  = cpd_pkg::KIND_CAM_OFF;
                                result.rearm = 1'b1;
                            end
                        end
                        cpd_pkg::CMD_WORD:
                        begin
                            if (word_idx_reg != LAST_IDX)
                            begin
                                word_idx_next = word_idx_reg + IDX_W'(1);
                            end
                            else
                            begin
                                word_idx_next = '0;
                                if (is_sync)
                                begin
                                    offset_next = '0;
                                    count_next  = '0;
                                    load        = 1'b1;
                                    result.kind = cpd_pkg::KIND_SYNC;
                                end
                                else if (is_end)
                                begin
                                    tmo_next     = '0;
                                    count_next   = '0;
                                    load         = 1'b1;
                                    result.rearm = 1'b1;
                                    result.kind  = (count_reg == frame_bytes_reg)
                                                 ? cpd_pkg::KIND_COMPLETE
                                                 : cpd_pkg::KIND_SHORT;
                                end
                                else
                                begin
                                    tmo_next = tmo_hit ? TW'(1) : tmo_reg + TW'(1);
                                    if (is_pixel)
                                    begin
                                        rearm_next    = tmo_hit;
                                        prev_low_next = w0_reg[15:0];
                                        rd_idx_next   = IDX_W'(1);
                                        state_next    = ST_PIXEL;
                                    end
                                    else
                                    begin
                                        load         = 1'b1;
                                        result.kind  = cpd_pkg::KIND_OTHER;
                                        result.rearm = tmo_hit;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PIXEL:
            begin
                mem_raddr = rd_idx_reg;
                if (can_load)
                begin
                    load              = 1'b1;
                    result.kind       = cpd_pkg::KIND_PIXEL;
                    result.write_addr = offset_ext[AW-1:0];
                    result.write_data = {prev_low_reg, mem_rdata[31:16]};
                    result.rearm      = rearm_reg;
                    result.last       = (rd_idx_reg == LAST_IDX);
                    prev_low_next     = mem_rdata[15:0];
                    offset_next       = offset_reg + OFFSET_BITS'(4);
                    count_next        = (count_reg > cpd_pkg::COUNT_SAT)
                                      ? cpd_pkg::COUNT_MAX : count_reg + CW'(4);
                    rd_idx_next       = rd_idx_reg + IDX_W'(1);
                    mem_raddr         = rd_idx_reg + IDX_W'(1);
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            word_idx_reg    <= '0;
            rd_idx_reg      <= '0;
            offset_reg      <= '0;
            count_reg       <= '0;
            tmo_reg         <= '0;
            cam_reg         <= 1'b0;
            rearm_reg       <= 1'b0;
            frame_bytes_reg <= cpd_pkg::FRAME_BYTES_RST;
            tmo_limit_reg   <= cpd_pkg::TIMEOUT_LIMIT_RST;
        end
        else
        begin
            state_reg    <= state_next;
            word_idx_reg <= word_idx_next;
            rd_idx_reg   <= rd_idx_next;
            offset_reg   <= offset_next;
            count_reg    <= count_next;
            tmo_reg      <= tmo_next;
            cam_reg      <= cam_next;
            rearm_reg    <= rearm_next;
            if (cfg_wr_en && (cfg_index == cpd_pkg::CFG_FRAME_BYTES))
            begin
                frame_bytes_reg <= cfg_data;
            end
            if (cfg_wr_en && (cfg_index == cpd_pkg::CFG_TIMEOUT_LIMIT))
            begin
                tmo_limit_reg <= cfg_data[TW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_low_reg <= prev_low_next;
        if (mem_we && (word_idx_reg == IDX_W'(0)))
        begin
            w0_reg <= s_tdata;
        end
        if (mem_we && (word_idx_reg == IDX_W'(1)))
        begin
            w1_reg <= s_tdata;
        end
    end

endmodule
